@@ rtl/euler_rotate_translate_project_core_assert.svh @@
// Assertion macros for the rotate, translate and project core.
`ifndef EULER_ROTATE_TRANSLATE_PROJECT_CORE_ASSERT_SVH
`define EULER_ROTATE_TRANSLATE_PROJECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ERP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ERP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ERP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ERP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/erp_pkg.sv @@
// Shared types, constants and helper functions of the rotate, translate and project core.
`default_nettype none
package erp_pkg;
	localparam int COORD_W = 24;
	localparam int ANGLE_W = 16;
	localparam int SCREEN_W = 16;
	localparam int CFG_W = (COORD_W > ANGLE_W) ?
		((COORD_W > SCREEN_W) ? COORD_W : SCREEN_W) :
		((ANGLE_W > SCREEN_W) ? ANGLE_W : SCREEN_W);
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ANGLE_X  = 3'd0,
		REG_ANGLE_Y  = 3'd1,
		REG_ANGLE_Z  = 3'd2,
		REG_MOVE_X   = 3'd3,
		REG_MOVE_Y   = 3'd4,
		REG_MOVE_Z   = 3'd5,
		REG_CENTRE_X = 3'd6,
		REG_CENTRE_Y = 3'd7
	} reg_idx_t;

	localparam logic [31:0] SIN_C1 = 32'd1686629713;
	localparam logic [31:0] SIN_C3 = 32'd693598668;
	localparam logic [31:0] SIN_C5 = 32'd85569306;
	localparam logic [31:0] SIN_C7 = 32'd5026995;
	localparam logic [31:0] SIN_C9 = 32'd172272;

	localparam int SINE_LAT = 7;
	localparam int MAT_LAT = SINE_LAT + 2;
	localparam int LATENCY = MAT_LAT + 6;

	typedef logic signed [15:0] trig_t;
	typedef logic signed [32:0] coef_t;
	typedef coef_t [8:0] mat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic last_point;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic signed [COORD_W-1:0] qz;
		logic signed [SCREEN_W-1:0] screen_x;
		logic signed [SCREEN_W-1:0] screen_y;
		logic last_out;
	} result_t;

	function automatic logic [15:0] phase16(input logic [ANGLE_W-1:0] a);
		logic [ANGLE_W+15:0] t;
		t = {a, 16'b0};
		return t[ANGLE_W+15 -: 16];
	endfunction

	function automatic logic [31:0] horner(input logic [31:0] c, input logic [31:0] acc,
		input logic [31:0] z2);
		logic [63:0] p;
		p = 64'(acc) * 64'(z2);
		return c - p[61:30];
	endfunction
endpackage
`default_nettype wire

@@ rtl/erp_sine.sv @@
// Pipelined Q1.15 sine of a 16-bit phase by a Taylor polynomial in Horner form.
`default_nettype none
module erp_sine (
	input  wire logic clk,
	input  wire logic [15:0] phase,
	output erp_pkg::trig_t sine
);
	logic [14:0] r;
	logic [30:0] z0;
	logic [61:0] zz;
	logic [31:0] z2_s1, z2_s2, z2_s3, z2_s4;
	logic [30:0] z_s1, z_s2, z_s3, z_s4, z_s5;
	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic [31:0] acc_s2, acc_s3, acc_s4, acc_s5, v_s6;
	logic [63:0] vp;
	logic [32:0] sr;
	logic [14:0] mag;
	erp_pkg::trig_t sine_s7;

	always_comb begin
		if (phase[14]) begin
			r = 15'd16384 - {1'b0, phase[13:0]};
		end else begin
			r = {1'b0, phase[13:0]};
		end
		z0 = {r, 16'b0};
		zz = 62'(z0) * 62'(z0);
		vp = 64'(acc_s5) * 64'(z_s5);
		sr = (33'(v_s6) + 33'd16384) >> 15;
		mag = (sr > 33'd32767) ? 15'h7fff : sr[14:0];
	end

	always_ff @(posedge clk) begin
		z2_s1 <= zz[61:30];
		z_s1 <= z0;
		quad_s1 <= phase[15:14];
		acc_s2 <= erp_pkg::horner(erp_pkg::SIN_C7, erp_pkg::SIN_C9, z2_s1);
		z2_s2 <= z2_s1;
		z_s2 <= z_s1;
		quad_s2 <= quad_s1;
		acc_s3 <= erp_pkg::horner(erp_pkg::SIN_C5, acc_s2, z2_s2);
		z2_s3 <= z2_s2;
		z_s3 <= z_s2;
		quad_s3 <= quad_s2;
		acc_s4 <= erp_pkg::horner(erp_pkg::SIN_C3, acc_s3, z2_s3);
		z2_s4 <= z2_s3;
		z_s4 <= z_s3;
		quad_s4 <= quad_s3;
		acc_s5 <= erp_pkg::horner(erp_pkg::SIN_C1, acc_s4, z2_s4);
		z_s5 <= z_s4;
		quad_s5 <= quad_s4;
		v_s6 <= vp[61:30];
		quad_s6 <= quad_s5;
		sine_s7 <= quad_s6[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign sine = sine_s7;
endmodule
`default_nettype wire

@@ rtl/erp_matrix.sv @@
// Builds the Q30 rotation matrix Rx*Ry*Rz from the three angle registers.
`default_nettype none
module erp_matrix (
	input  wire logic clk,
	input  wire logic [erp_pkg::ANGLE_W-1:0] angle_x,
	input  wire logic [erp_pkg::ANGLE_W-1:0] angle_y,
	input  wire logic [erp_pkg::ANGLE_W-1:0] angle_z,
	output erp_pkg::mat_t mat
);
	logic [15:0] pa, pb, pc;
	erp_pkg::trig_t sx, cx, sy, cy, sz, cz;
	erp_pkg::trig_t sx_s8, cx_s8, sy_s8, cy_s8, sz_s8, cz_s8, sxsy_s8, cxsy_s8;
	logic signed [31:0] p_sxsy, p_cxsy, r_sxsy, r_cxsy;
	erp_pkg::mat_t mat_s9;

	assign pa = erp_pkg::phase16(angle_x);
	assign pb = erp_pkg::phase16(angle_y);
	assign pc = erp_pkg::phase16(angle_z);

	erp_sine u_sin_x (.clk(clk), .phase(pa), .sine(sx));
	erp_sine u_cos_x (.clk(clk), .phase(pa + 16'd16384), .sine(cx));
	erp_sine u_sin_y (.clk(clk), .phase(pb), .sine(sy));
	erp_sine u_cos_y (.clk(clk), .phase(pb + 16'd16384), .sine(cy));
	erp_sine u_sin_z (.clk(clk), .phase(pc), .sine(sz));
	erp_sine u_cos_z (.clk(clk), .phase(pc + 16'd16384), .sine(cz));

	always_comb begin
		p_sxsy = 32'(sx) * 32'(sy);
		p_cxsy = 32'(cx) * 32'(sy);
		r_sxsy = (p_sxsy + 32'sd16384) >>> 15;
		r_cxsy = (p_cxsy + 32'sd16384) >>> 15;
	end

	always_ff @(posedge clk) begin
		sx_s8 <= sx;
		cx_s8 <= cx;
		sy_s8 <= sy;
		cy_s8 <= cy;
		sz_s8 <= sz;
		cz_s8 <= cz;
		sxsy_s8 <= r_sxsy[15:0];
		cxsy_s8 <= r_cxsy[15:0];
		mat_s9[0] <= 33'(cy_s8) * 33'(cz_s8);
		mat_s9[1] <= -(33'(cy_s8) * 33'(sz_s8));
		mat_s9[2] <= 33'(sy_s8) <<< 15;
		mat_s9[3] <= 33'(sxsy_s8) * 33'(cz_s8) + 33'(cx_s8) * 33'(sz_s8);
		mat_s9[4] <= 33'(cx_s8) * 33'(cz_s8) - 33'(sxsy_s8) * 33'(sz_s8);
		mat_s9[5] <= -(33'(sx_s8) * 33'(cy_s8));
		mat_s9[6] <= 33'(sx_s8) * 33'(sz_s8) - 33'(cxsy_s8) * 33'(cz_s8);
		mat_s9[7] <= 33'(cxsy_s8) * 33'(sz_s8) + 33'(sx_s8) * 33'(cz_s8);
		mat_s9[8] <= 33'(cx_s8) * 33'(cy_s8);
	end

	assign mat = mat_s9;
endmodule
`default_nettype wire

@@ rtl/erp_xform.sv @@
// Point pipeline: alignment delay, matrix products, rounding, translation and saturation.
`default_nettype none
module erp_xform (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire erp_pkg::point_t point,
	input  wire erp_pkg::mat_t mat,
	input  wire logic signed [erp_pkg::COORD_W-1:0] move_x,
	input  wire logic signed [erp_pkg::COORD_W-1:0] move_y,
	input  wire logic signed [erp_pkg::COORD_W-1:0] move_z,
	output erp_pkg::point_t q,
	output logic q_valid
);
	localparam int CW = erp_pkg::COORD_W;
	localparam int DLY = erp_pkg::MAT_LAT;
	localparam int PW = 33 + CW;
	localparam int QW = CW + 6;
	localparam logic signed [PW+1:0] RND = (PW+2)'(1) <<< 29;
	localparam logic signed [QW-1:0] CMAX = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [QW-1:0] CMIN = {{(QW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	erp_pkg::point_t dly_s [DLY];
	logic [DLY-1:0] dv_s;
	logic signed [PW-1:0] prod_s10 [9];
	logic last_s10, last_s11;
	logic v_s10, v_s11, v_s12;
	logic signed [QW-1:0] sum_s11 [3];
	logic signed [CW-1:0] sat [3];
	logic signed [CW-1:0] crd [3];
	logic signed [CW-1:0] mv [3];
	logic signed [PW+1:0] acc [3];
	logic signed [PW+1:0] sh [3];
	erp_pkg::point_t q_s12;

	always_comb begin
		crd[0] = dly_s[DLY-1].px;
		crd[1] = dly_s[DLY-1].py;
		crd[2] = dly_s[DLY-1].pz;
		mv[0] = move_x;
		mv[1] = move_y;
		mv[2] = move_z;
		for (int i = 0; i < 3; i++) begin
			acc[i] = (PW+2)'(prod_s10[3*i]) + (PW+2)'(prod_s10[3*i+1])
				+ (PW+2)'(prod_s10[3*i+2]) + RND;
			sh[i] = acc[i] >>> 30;
			if (sum_s11[i] > CMAX) begin
				sat[i] = CMAX[CW-1:0];
			end else if (sum_s11[i] < CMIN) begin
				sat[i] = CMIN[CW-1:0];
			end else begin
				sat[i] = sum_s11[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			dv_s <= {dv_s[DLY-2:0], in_valid};
			v_s10 <= dv_s[DLY-1];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		dly_s[0] <= point;
		for (int i = 1; i < DLY; i++) begin
			dly_s[i] <= dly_s[i-1];
		end
		for (int i = 0; i < 9; i++) begin
			prod_s10[i] <= PW'($signed(mat[i])) * PW'(crd[i%3]);
		end
		last_s10 <= dly_s[DLY-1].last_point;
		for (int i = 0; i < 3; i++) begin
			sum_s11[i] <= $signed(sh[i][QW-1:0]) + QW'(mv[i]);
		end
		last_s11 <= last_s10;
		q_s12.px <= sat[0];
		q_s12.py <= sat[1];
		q_s12.pz <= sat[2];
		q_s12.last_point <= last_s11;
	end

	assign q = q_s12;
	assign q_valid = v_s12;
endmodule
`default_nettype wire

@@ rtl/erp_project.sv @@
// Oblique projection of the moved point to the screen, with saturation.
`default_nettype none
module erp_project (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire erp_pkg::point_t q,
	input  wire logic q_valid,
	input  wire logic signed [erp_pkg::SCREEN_W-1:0] centre_x,
	input  wire logic signed [erp_pkg::SCREEN_W-1:0] centre_y,
	output erp_pkg::result_t res,
	output logic done
);
	localparam int CW = erp_pkg::COORD_W;
	localparam int SW = erp_pkg::SCREEN_W;
	localparam int MB = CW - 6;
	localparam int K = MB + 3;
	localparam int RW = K - 2;
	localparam int DW = MB + RW;
	localparam int TW = DW - K;
	localparam int SUMW = CW + 2;
	localparam longint RECIP = ((64'sd1 <<< K) + 64'sd4) / 64'sd5;
	localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-SW+1){1'b1}}, {(SW-1){1'b0}}};

	logic [CW-1:0] ax;
	logic [CW+1:0] ax3;
	logic signed [CW-1:0] ty_full, tz_full;
	logic [MB-1:0] a3_s13, a1_s13;
	logic sgn_s13, sgn_s14;
	logic signed [CW-9:0] ty_s13, tz_s13, ty_s14, tz_s14;
	erp_pkg::point_t q_s13, q_s14;
	logic [DW-1:0] d3_s14, d1_s14;
	logic [DW-1:0] t2w, t4w;
	logic signed [SUMW-1:0] t2, t4, sx_sum, sy_sum;
	logic signed [SW-1:0] sx_sat, sy_sat;
	logic v_s13, v_s14, v_s15;
	erp_pkg::result_t res_s15;

	always_comb begin
		ax = q.px[CW-1] ? CW'(-q.px) : q.px;
		ax3 = (CW+2)'(ax) * (CW+2)'(3);
		ty_full = q.py + (q.py[CW-1] ? CW'(255) : CW'(0));
		tz_full = q.pz + (q.pz[CW-1] ? CW'(255) : CW'(0));
		t2w = d3_s14 >> K;
		t4w = d1_s14 >> K;
		t2 = $signed(SUMW'(t2w[TW-1:0]));
		t4 = $signed(SUMW'(t4w[TW-1:0]));
		if (sgn_s14) begin
			t2 = -t2;
			t4 = -t4;
		end
		sx_sum = SUMW'(centre_x) - SUMW'(ty_s14) + t2;
		sy_sum = SUMW'(centre_y) - SUMW'(tz_s14) + t4;
		if (sx_sum > SMAX) begin
			sx_sat = SMAX[SW-1:0];
		end else if (sx_sum < SMIN) begin
			sx_sat = SMIN[SW-1:0];
		end else begin
			sx_sat = sx_sum[SW-1:0];
		end
		if (sy_sum > SMAX) begin
			sy_sat = SMAX[SW-1:0];
		end else if (sy_sum < SMIN) begin
			sy_sat = SMIN[SW-1:0];
		end else begin
			sy_sat = sy_sum[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else begin
			v_s13 <= q_valid;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		a3_s13 <= ax3[CW+1:8];
		a1_s13 <= MB'(ax[CW-1:7]);
		sgn_s13 <= q.px[CW-1];
		ty_s13 <= ty_full[CW-1:8];
		tz_s13 <= tz_full[CW-1:8];
		q_s13 <= q;
		d3_s14 <= DW'(a3_s13) * DW'(RECIP);
		d1_s14 <= DW'(a1_s13) * DW'(RECIP);
		sgn_s14 <= sgn_s13;
		ty_s14 <= ty_s13;
		tz_s14 <= tz_s13;
		q_s14 <= q_s13;
		res_s15.qx <= q_s14.px;
		res_s15.qy <= q_s14.py;
		res_s15.qz <= q_s14.pz;
		res_s15.screen_x <= sx_sat;
		res_s15.screen_y <= sy_sat;
		res_s15.last_out <= q_s14.last_point;
	end

	assign res = res_s15;
	assign done = v_s15;
endmodule
`default_nettype wire

@@ rtl/euler_rotate_translate_project_core.sv @@
// Top level of the rotate, translate and project core with its register file.
// A new point may be started in every cycle, so busy stays low. The rotation
// matrix is rebuilt by a nine-stage sine and product pipeline after an angle
// write; each point is held in a matching nine-stage delay so that it meets the
// matrix of the registers it was started under. Results appear for one cycle
// with done and cannot be stalled.
`default_nettype none
`include "euler_rotate_translate_project_core_assert.svh"
module euler_rotate_translate_project_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire erp_pkg::point_t point,
	output logic done,
	output erp_pkg::result_t result,
	input  wire logic cfg_we,
	input  wire logic [erp_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [erp_pkg::CFG_W-1:0] cfg_data
);
	localparam int CW = erp_pkg::COORD_W;
	localparam int AW = erp_pkg::ANGLE_W;
	localparam int SW = erp_pkg::SCREEN_W;

	logic [AW-1:0] angle_x_q, angle_y_q, angle_z_q;
	logic signed [CW-1:0] move_x_q, move_y_q, move_z_q;
	logic signed [SW-1:0] centre_x_q, centre_y_q;
	erp_pkg::mat_t mat;
	erp_pkg::point_t q;
	logic q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q <= '0;
			angle_y_q <= '0;
			angle_z_q <= '0;
			move_x_q <= '0;
			move_y_q <= '0;
			move_z_q <= '0;
			centre_x_q <= '0;
			centre_y_q <= '0;
		end else if (cfg_we) begin
			unique case (erp_pkg::reg_idx_t'(cfg_index))
				erp_pkg::REG_ANGLE_X: angle_x_q <= cfg_data[AW-1:0];
				erp_pkg::REG_ANGLE_Y: angle_y_q <= cfg_data[AW-1:0];
				erp_pkg::REG_ANGLE_Z: angle_z_q <= cfg_data[AW-1:0];
				erp_pkg::REG_MOVE_X: move_x_q <= cfg_data[CW-1:0];
				erp_pkg::REG_MOVE_Y: move_y_q <= cfg_data[CW-1:0];
				erp_pkg::REG_MOVE_Z: move_z_q <= cfg_data[CW-1:0];
				erp_pkg::REG_CENTRE_X: centre_x_q <= cfg_data[SW-1:0];
				erp_pkg::REG_CENTRE_Y: centre_y_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	erp_matrix u_matrix (
		.clk(clk),
		.angle_x(angle_x_q),
		.angle_y(angle_y_q),
		.angle_z(angle_z_q),
		.mat(mat)
	);

	erp_xform u_xform (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.point(point),
		.mat(mat),
		.move_x(move_x_q),
		.move_y(move_y_q),
		.move_z(move_z_q),
		.q(q),
		.q_valid(q_valid)
	);

	erp_project u_project (
		.clk(clk),
		.arst_n(arst_n),
		.q(q),
		.q_valid(q_valid),
		.centre_x(centre_x_q),
		.centre_y(centre_y_q),
		.res(result),
		.done(done)
	);

	`ERP_ASSERT_NEVER(a_done_without_request, done && !$past(start, erp_pkg::LATENCY), "done without a request")
	`ERP_ASSERT_IMPLY(a_last_kept, done, result.last_out == $past(point.last_point, erp_pkg::LATENCY), "last flag lost")
endmodule
`default_nettype wire
